>>> src/cfnpm_pkg.sv
// ============================================================================
// cfnpm_pkg - shared constants for the case-folding name pattern matcher
// Character codes, pattern geometry, match modes and register indexes.
// ============================================================================
`default_nettype none

package cfnpm_pkg;

    // Pattern geometry
    localparam int MAX_PATTERN = 32;
    localparam int POS_W       = MAX_PATTERN + 1;     // live position vector width
    localparam int LEN_W       = 6;                   // pattern_length register width
    localparam int CHAR_W      = 8;
    localparam int WORD_W      = 64;
    localparam int PATTERN_W   = MAX_PATTERN * CHAR_W;

    // Configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = WORD_W;

    localparam logic [CFG_ADDR_W-1:0] REG_MATCH_MODE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_WORD_0 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_WORD_1 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_WORD_2 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_WORD_3 = 3'd5;

    // Match modes
    localparam logic [1:0] MODE_EXACT     = 2'd0;
    localparam logic [1:0] MODE_GLOB      = 2'd1;
    localparam logic [1:0] MODE_SUBSTRING = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUEST   = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    // Fold A..Z to a..z, leave every other byte alone.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + (CH_LOWER_A - CH_UPPER_A);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/case_folding_name_pattern_matcher.sv
// ============================================================================
// case_folding_name_pattern_matcher - streaming glob / exact / substring match
// Throughput: one transaction per cycle, except while a finished name waits
// on a held result that is not being taken. The live position vector update
// uses one 33-bit carry chain for the glob star closure.
// Reset: mode substring, empty pattern, no result pending, matcher at the
// start of a name.
// ============================================================================
`default_nettype none

module case_folding_name_pattern_matcher
    import cfnpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Character stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] char_code
    input  wire logic                  s_axis_tuser,   // [0] no_char
    input  wire logic                  s_axis_tlast,   // string_end

    // Match result out, one transaction per name
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata    // [0] matched, [7:1] zero
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [1:0]           mode_reg;
    logic [LEN_W-1:0]     len_cfg_reg;
    logic [PATTERN_W-1:0] pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SUBSTRING;
            len_cfg_reg <= '0;
            pattern_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MATCH_MODE:     mode_reg    <= cfg_wdata[1:0];
                REG_PATTERN_LENGTH: len_cfg_reg <= cfg_wdata[LEN_W-1:0];
                REG_PATTERN_WORD_0: pattern_reg[0*WORD_W +: WORD_W] <= cfg_wdata;
                REG_PATTERN_WORD_1: pattern_reg[1*WORD_W +: WORD_W] <= cfg_wdata;
                REG_PATTERN_WORD_2: pattern_reg[2*WORD_W +: WORD_W] <= cfg_wdata;
                REG_PATTERN_WORD_3: pattern_reg[3*WORD_W +: WORD_W] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Derived pattern information, recomputed every cycle and registered.
    // Configuration must only change while the block is idle; the block itself
    // does not enforce this. An item that arrives right after a write passes
    // through the input register, so these registers are current when it is evaluated.
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]       len_next,   len_reg;
    logic [POS_W-1:0]       mask_next,  mask_reg;    // bit i: i <= length
    logic [MAX_PATTERN-1:0] star_next,  star_reg;    // glob-only wildcard '*'
    logic [MAX_PATTERN-1:0] quest_next, quest_reg;   // glob-only wildcard '?'
    logic [POS_W-1:0]       tail_next,  tail_reg;    // bit i: only stars from i on

    always_comb
    begin
        // Lengths above the pattern capacity count as a full pattern.
        if (len_cfg_reg > LEN_W'(MAX_PATTERN))
        begin
            len_next = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_next = len_cfg_reg;
        end

        for (int i = 0; i < POS_W; i++)
        begin
            mask_next[i] = (LEN_W'(i) <= len_next);
        end

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            star_next[i]  = (mode_reg == MODE_GLOB) && mask_next[i+1] &&
                            (pattern_reg[i*CHAR_W +: CHAR_W] == CH_STAR);
            quest_next[i] = (mode_reg == MODE_GLOB) && mask_next[i+1] &&
                            (pattern_reg[i*CHAR_W +: CHAR_W] == CH_QUEST);
        end
    end

    // A position reaches the end of the pattern over stars alone when every
    // pattern character from there to the end is a glob star. Outside glob
    // mode only the end position itself qualifies.
    always_comb
    begin
        for (int j = 0; j < POS_W; j++)
        begin
            tail_next[j] = mask_next[j];
            for (int k = j; k < MAX_PATTERN; k++)
            begin
                if (mask_next[k+1] && !star_next[k])
                begin
                    tail_next[j] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            mask_reg  <= {{(POS_W-1){1'b0}}, 1'b1};
            star_reg  <= '0;
            quest_reg <= '0;
            tail_reg  <= {{(POS_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            len_reg   <= len_next;
            mask_reg  <= mask_next;
            star_reg  <= star_next;
            quest_reg <= quest_next;
            tail_reg  <= tail_next;
        end
    end

    // ------------------------------------------------------------------------
    // Input register. The character is case-folded on the way in.
    // ------------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_no_char_reg;
    logic              in_end_reg;
    logic              advance;

    // The evaluation stage moves on unless it would produce a result while the
    // output register still holds one that is not being taken.
    assign advance       = in_valid_reg && (!in_end_reg || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg    <= fold_char(s_axis_tdata);
            in_no_char_reg <= s_axis_tuser;
            in_end_reg     <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------------
    // Live position vector update.
    // Bit i of the vector means the first i pattern characters are matched.
    // The stored vector is kept as stepped; in glob mode every position
    // reachable by skipping '*' characters is added each time it is used.
    // ------------------------------------------------------------------------
    logic [POS_W-1:0] live_reg;
    logic             found_reg;

    logic [POS_W-1:0]       live_eff;
    logic [POS_W-1:0]       live_clo;
    logic [MAX_PATTERN-1:0] hit_adv;
    logic [MAX_PATTERN-1:0] hit_stay;
    logic [POS_W-1:0]       step_vec;
    logic [POS_W-1:0]       clo_p;
    logic [POS_W-1:0]       clo_g;
    logic [POS_W-1:0]       clo_sum;
    logic [POS_W-1:0]       live_new;
    logic                   found_new;
    logic                   matched_now;

    always_comb
    begin
        // Positions beyond the current length are dropped.
        live_eff = live_reg & mask_reg;

        // Star closure as a carry chain: a live bit on a star generates a
        // carry, which runs on through the following stars. Outside glob mode
        // the star vector is empty and this leaves the vector as it is.
        clo_p    = {1'b0, star_reg};
        clo_g    = live_eff & clo_p;
        clo_sum  = clo_p + clo_g;
        live_clo = live_eff | (clo_sum ^ clo_p ^ clo_g);

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            // A star holds its position; any other active character advances
            // on an equal byte, or on any byte for a glob '?'.
            hit_stay[i] = live_clo[i] && star_reg[i];
            hit_adv[i]  = live_clo[i] && mask_reg[i+1] && !star_reg[i] &&
                          ((pattern_reg[i*CHAR_W +: CHAR_W] == in_char_reg) ||
                           quest_reg[i]);
        end

        step_vec = {hit_adv, 1'b0} | {1'b0, hit_stay};
        if (mode_reg == MODE_SUBSTRING)
        begin
            // A substring may begin at any character.
            step_vec[0] = 1'b1;
        end

        if (in_no_char_reg)
        begin
            live_new  = live_eff;
            found_new = found_reg;
        end
        else
        begin
            live_new  = step_vec;
            found_new = found_reg ||
                        ((mode_reg == MODE_SUBSTRING) && step_vec[len_reg]);
        end

        case (mode_reg)
            MODE_EXACT:     matched_now = (len_reg != '0) && live_new[len_reg];
            MODE_GLOB:      matched_now = |(live_new & tail_reg);
            MODE_SUBSTRING: matched_now = found_new || live_new[len_reg];
            default:        matched_now = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= {{(POS_W-1){1'b0}}, 1'b1};
            found_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_end_reg)
            begin
                // Name finished: back to the start of the next name.
                live_reg  <= {{(POS_W-1){1'b0}}, 1'b1};
                found_reg <= 1'b0;
            end
            else
            begin
                live_reg  <= live_new;
                found_reg <= found_new;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register, one transaction per finished name.
    // ------------------------------------------------------------------------
    logic out_valid_reg;
    logic out_matched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_end_reg)
        begin
            out_matched_reg <= matched_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_matched_reg};

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the case-folding name pattern matcher
// Streams names one byte per transaction into the matcher under exact, glob,
// substring and unused modes, predicts each per-name match bit with an
// independent position-vector model, and compares every result transaction
// in order. Both stream sides idle and stall at random.
// ============================================================================

module tb_top;

    import cfnpm_pkg::*;

    // The register is two bits wide, so the fourth mode value is reachable.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One input transaction: a byte, a no-character flag and the end-of-name mark.
    typedef struct packed {
        logic [7:0] code;
        logic       no_chr;
        logic       fin;
    } name_item_t;

    logic                  clk;
    logic                  rst_n = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] char_code
    logic                  s_axis_tuser  = 1'b0; // [0] no_char
    logic                  s_axis_tlast  = 1'b0; // string_end

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [0] matched, [7:1] zero

    case_folding_name_pattern_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the matcher hangs.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the matcher: registers plus per-name state.
    // ------------------------------------------------------------------------
    logic [1:0]  mode_sh;
    logic [5:0]  plen_sh;
    logic [63:0] pat_sh [4];
    logic [32:0] live_sh;     // bit i: first i pattern characters matched
    logic        found_sh;    // substring mode has seen a full match

    name_item_t  pending_chars_q [$];   // transactions waiting for the driver
    logic [7:0]  match_expect_q [$];    // predicted result bytes, oldest first
    int          chars_queued   = 0;
    int          chars_accepted = 0;
    int          error_count    = 0;

    // Both sides stop idling while this window of input transactions passes.
    wire steady = (chars_accepted >= 350) && (chars_accepted < 520);

    function automatic logic [7:0] pat_char(input int i);
        return pat_sh[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Glob: any live position that sits on a star also makes the next one live.
    // The walk is in ascending order so runs of stars chain through.
    function automatic logic [32:0] skip_stars(input logic [32:0] v, input int len);
        for (int i = 0; i < len; i++)
        begin
            if (v[i] && pat_char(i) == CH_STAR)
            begin
                v[i + 1] = 1'b1;
            end
        end
        return v;
    endfunction

    // Advances the shadow state by one transaction. Returns 1 when the
    // transaction closes a name, with the expected match bit in hit.
    function automatic bit predict_match(input logic [7:0] code, input logic no_chr,
                                         input logic fin, output logic hit);
        int          len;
        logic [33:0] wide_mask;
        logic [32:0] mask;
        logic [32:0] live;
        logic [32:0] nxt;
        logic [32:0] clo;
        logic [7:0]  c;
        logic [7:0]  p;
        bit          glob;

        len       = (plen_sh > MAX_PATTERN) ? MAX_PATTERN : int'(plen_sh);
        wide_mask = (34'd1 << (len + 1)) - 34'd1;
        mask      = wide_mask[32:0];
        live      = live_sh & mask;
        glob      = (mode_sh == MODE_GLOB);
        hit       = 1'b0;

        if (!no_chr)
        begin
            c = code;
            if (code >= CH_UPPER_A && code <= CH_UPPER_Z)
            begin
                c = code + (CH_LOWER_A - CH_UPPER_A);
            end
            if (glob)
            begin
                live = skip_stars(live, len);
            end
            nxt = '0;
            for (int i = 0; i < len; i++)
            begin
                if (live[i])
                begin
                    p = pat_char(i);
                    // A star holds its position; anything else moves on by one.
                    if (glob && p == CH_STAR)
                    begin
                        nxt[i] = 1'b1;
                    end
                    else if (p == c || (glob && p == CH_QUEST))
                    begin
                        nxt[i + 1] = 1'b1;
                    end
                end
            end
            if (mode_sh == MODE_SUBSTRING)
            begin
                // A match may start at any character of the name.
                nxt[0] = 1'b1;
                if (nxt[len])
                begin
                    found_sh = 1'b1;
                end
            end
            live = nxt & mask;
        end
        live_sh = live;

        if (!fin)
        begin
            return 1'b0;
        end

        clo = skip_stars(live, len);
        case (mode_sh)
            MODE_EXACT:     hit = (len != 0) && live[len];
            MODE_GLOB:      hit = clo[len];
            MODE_SUBSTRING: hit = found_sh || live[len];
            default:        hit = 1'b0;
        endcase
        live_sh  = 33'd1;
        found_sh = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued transactions, idling at random, and runs the
    // predictor on every transaction the matcher accepts.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        name_item_t nxt_item;
        logic       hit;

        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_match(s_axis_tdata, s_axis_tuser, s_axis_tlast, hit))
                begin
                    match_expect_q.insert(match_expect_q.size(), {7'd0, hit});
                end
                chars_accepted <= chars_accepted + 1;
            end
            // The bus may change only when nothing is on offer or the
            // current transaction has just been taken.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_chars_q.size() != 0 && (steady || $urandom_range(99) >= 33))
                begin
                    nxt_item = pending_chars_q.pop_front();
                    s_axis_tdata  <= nxt_item.code;
                    s_axis_tuser  <= nxt_item.no_chr;
                    s_axis_tlast  <= nxt_item.fin;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction
    // and drives the result-side ready. A few times it holds ready low for a
    // long stretch so the matcher backs up and stalls its input.
    // ------------------------------------------------------------------------
    int results_seen = 0;
    int hold_cycles  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic       rdy;
        logic [7:0] want;

        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (match_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = match_expect_q.pop_front();
                    if (m_axis_tdata[0] !== want[0])
                    begin
                        $display("%0t: matched mismatch, expected %b, actual %b",
                                 $time, want[0], m_axis_tdata[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[7:1] !== want[7:1])
                    begin
                        $display("%0t: padding mismatch, expected %h, actual %h",
                                 $time, want[7:1], m_axis_tdata[7:1]);
                        error_count++;
                    end
                end
                results_seen++;
                if (results_seen == 30 || results_seen == 100 || results_seen == 170)
                begin
                    hold_cycles = 150;
                end
            end

            if (hold_cycles != 0)
            begin
                hold_cycles--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = steady || ($urandom_range(99) >= 33);
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------------
    logic [7:0] pat_buf [32];       // pattern bytes for the next load
    name_item_t name_buf [$];       // one generated name, before queueing

    // Call just after a rising edge; leaves the write enable high so that
    // back-to-back writes need no second assignment in one time step.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MATCH_MODE:     mode_sh = val[1:0];
            REG_PATTERN_LENGTH: plen_sh = val[5:0];
            REG_PATTERN_WORD_0: pat_sh[0] = val;
            REG_PATTERN_WORD_1: pat_sh[1] = val;
            REG_PATTERN_WORD_2: pat_sh[2] = val;
            REG_PATTERN_WORD_3: pat_sh[3] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Loads mode, length and all four pattern words from pat_buf, then
    // steps to the falling edge so the caller can queue transactions.
    task automatic program_pattern(input logic [1:0] m, input logic [5:0] n);
        logic [63:0] w [4];

        for (int i = 0; i < 32; i++)
        begin
            w[i / 8][(i % 8) * 8 +: 8] = pat_buf[i];
        end
        write_reg(REG_MATCH_MODE, {62'd0, m});
        write_reg(REG_PATTERN_LENGTH, {58'd0, n});
        write_reg(REG_PATTERN_WORD_0, w[0]);
        write_reg(REG_PATTERN_WORD_1, w[1]);
        write_reg(REG_PATTERN_WORD_2, w[2]);
        write_reg(REG_PATTERN_WORD_3, w[3]);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic text_pattern(input string s, input logic [7:0] fill);
        for (int i = 0; i < 32; i++)
        begin
            pat_buf[i] = (i < s.len()) ? s[i] : fill;
        end
    endtask

    task automatic queue_item(input logic [7:0] code, input logic no_chr, input logic fin);
        pending_chars_q.insert(pending_chars_q.size(),
                               name_item_t'{code: code, no_chr: no_chr, fin: fin});
        chars_queued++;
    endtask

    // Queues a text as one name; the end mark rides on its last byte.
    task automatic queue_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_item(s[i], 1'b0, close && (i == s.len() - 1));
        end
    endtask

    // Waits until the matcher has taken every transaction and returned every
    // predicted result, then lets its pipeline settle. Ends on a rising edge.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (chars_accepted != chars_queued || match_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Name characters are mostly from a small alphabet so that matches
    // happen often; the rest are arbitrary bytes.
    function automatic logic [7:0] pick_char();
        string alpha;

        alpha = "abcAB*?";
        if ($urandom_range(99) < 75)
        begin
            return alpha[$urandom_range(alpha.len() - 1)];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic random_pattern(output logic [1:0] m, output logic [5:0] n);
        int    r;
        string alpha;

        alpha = "abc*?a*";
        r = $urandom_range(99);
        m = (r < 30) ? MODE_EXACT : (r < 60) ? MODE_GLOB :
            (r < 95) ? MODE_SUBSTRING : MODE_UNUSED;
        r = $urandom_range(99);
        n = (r < 75) ? 6'($urandom_range(6)) :
            (r < 92) ? 6'($urandom_range(32, 7)) : 6'($urandom_range(63, 33));
        for (int i = 0; i < 32; i++)
        begin
            pat_buf[i] = ($urandom_range(99) < 95) ? alpha[$urandom_range(alpha.len() - 1)]
                                                 : 8'($urandom_range(255));
        end
    endtask

    // Builds one name into name_buf. Most names follow the pattern (stars
    // expanded, question marks filled, letters in random case, an occasional
    // corruption); the rest are free text. No-character transactions are
    // sprinkled in as noise.
    task automatic random_name(input logic [1:0] m, input logic [5:0] n);
        logic [7:0] txt [$];
        logic [7:0] p;
        int         len;
        int         k;

        len = (n > MAX_PATTERN) ? MAX_PATTERN : int'(n);
        name_buf.delete();
        if ($urandom_range(99) < 70)
        begin
            if (m == MODE_SUBSTRING)
            begin
                repeat ($urandom_range(3)) txt.insert(txt.size(), pick_char());
            end
            for (int i = 0; i < len; i++)
            begin
                p = pat_buf[i];
                if (m == MODE_GLOB && p == CH_STAR)
                begin
                    repeat ($urandom_range(3)) txt.insert(txt.size(), pick_char());
                end
                else if (m == MODE_GLOB && p == CH_QUEST)
                begin
                    txt.insert(txt.size(), pick_char());
                end
                else if (p >= CH_LOWER_A && p < CH_LOWER_A + 26 && $urandom_range(1) == 1)
                begin
                    txt.insert(txt.size(), p - (CH_LOWER_A - CH_UPPER_A));
                end
                else
                begin
                    txt.insert(txt.size(), p);
                end
            end
            if (m == MODE_SUBSTRING)
            begin
                repeat ($urandom_range(3)) txt.insert(txt.size(), pick_char());
            end
            if (txt.size() != 0 && $urandom_range(9) == 0)
            begin
                k = $urandom_range(txt.size() - 1);
                if ($urandom_range(1) == 1)
                begin
                    txt[k] = pick_char();
                end
                else
                begin
                    txt.delete(k);
                end
            end
        end
        else
        begin
            repeat ($urandom_range(10)) txt.insert(txt.size(), pick_char());
        end

        foreach (txt[i])
        begin
            if ($urandom_range(99) < 8)
            begin
                name_buf.insert(name_buf.size(),
                                name_item_t'{code: 8'($urandom_range(255)), no_chr: 1'b1,
                                             fin: 1'b0});
            end
            name_buf.insert(name_buf.size(),
                            name_item_t'{code: txt[i], no_chr: 1'b0, fin: 1'b0});
        end
        // An empty name, or now and then a trailing mark, closes with a
        // no-character transaction; otherwise the last byte carries the end.
        if (name_buf.size() == 0 || $urandom_range(9) == 0)
        begin
            name_buf.insert(name_buf.size(),
                            name_item_t'{code: 8'($urandom_range(255)), no_chr: 1'b1,
                                         fin: 1'b1});
        end
        else
        begin
            name_buf[name_buf.size() - 1].fin = 1'b1;
        end
    endtask

    initial
    begin
        logic [1:0] m;
        logic [5:0] n;
        int         random_chars;
        int         phase_target;
        int         phase_chars;

        // Register and matcher state after reset.
        mode_sh  = MODE_SUBSTRING;
        plen_sh  = '0;
        for (int i = 0; i < 4; i++)
        begin
            pat_sh[i] = '0;
        end
        live_sh  = 33'd1;
        found_sh = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: an empty pattern in substring mode matches the
        // empty name.
        queue_item(8'h00, 1'b1, 1'b1);
        wait_drained();

        // Exact match with case folding and a no-character transaction in
        // the middle of the name; the unused pattern bytes are all ones.
        text_pattern("abc", 8'hFF);
        program_pattern(MODE_EXACT, 6'd3);
        queue_item("A", 1'b0, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_text("bC", 1'b1);
        queue_text("ab", 1'b1);
        wait_drained();

        // Glob with star and question mark, including a literal star in the
        // name where the pattern has a wildcard star.
        text_pattern("a*?c", 8'h00);
        program_pattern(MODE_GLOB, 6'd4);
        queue_text("abc", 1'b1);
        queue_text("a*c", 1'b1);
        queue_text("ab", 1'b1);
        wait_drained();

        // Substring mode treats star as an ordinary byte.
        text_pattern("**", 8'h00);
        program_pattern(MODE_SUBSTRING, 6'd2);
        queue_text("x**", 1'b1);
        wait_drained();

        // Unused mode with an oversized length never matches.
        text_pattern("", 8'h00);
        program_pattern(MODE_UNUSED, 6'd63);
        queue_item(8'h00, 1'b0, 1'b1);
        wait_drained();

        // Exact mode with an empty pattern never matches.
        program_pattern(MODE_EXACT, 6'd0);
        queue_item(8'hFF, 1'b0, 1'b1);
        wait_drained();

        // Registers rewritten in the middle of a name: the live positions
        // carry over into the new settings.
        text_pattern("", "a");
        program_pattern(MODE_SUBSTRING, 6'd32);
        queue_text("aa", 1'b0);
        wait_drained();
        text_pattern("a", 8'h00);
        program_pattern(MODE_EXACT, 6'd1);
        queue_text("A", 1'b1);
        wait_drained();

        // Full-length pattern of stars, name closed by a no-character mark.
        text_pattern("", CH_STAR);
        program_pattern(MODE_GLOB, 6'd32);
        queue_item("Z", 1'b0, 1'b0);
        queue_item(8'h5B, 1'b1, 1'b1);
        wait_drained();

        // Random phases: a fresh configuration, then a batch of names. Each
        // phase ends with the sender paused until all results are back.
        random_chars = 0;
        while (random_chars < 850)
        begin
            random_pattern(m, n);
            program_pattern(m, n);
            phase_target = $urandom_range(90, 40);
            phase_chars  = 0;
            while (phase_chars < phase_target)
            begin
                random_name(m, n);
                // Occasionally leave the last name open across the next
                // register update.
                if (phase_chars + name_buf.size() >= phase_target && $urandom_range(9) == 0)
                begin
                    name_buf[name_buf.size() - 1].fin = 1'b0;
                end
                foreach (name_buf[i])
                begin
                    queue_item(name_buf[i].code, name_buf[i].no_chr, name_buf[i].fin);
                end
                phase_chars += name_buf.size();
            end
            random_chars += phase_chars;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (match_expect_q.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, match_expect_q.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
